>>> rtl/core/dcwl_pkg.sv
// shared types and constants of the delta coded word list lookup
// item structs for both channels, letter table entry, delta tags and word builder
// no dependencies
package dcwl_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [15:0] result_number;
		logic        word_written;
		logic [39:0] out_word;
	} result_item_t;

	typedef struct packed {
		logic [15:0] end_offset;
		logic [15:0] word_count;
	} letter_entry_t;

	// one header byte headed for the letter table
	typedef struct packed {
		logic       valid;
		logic [1:0] sel;
		logic [7:0] data;
	} table_write_t;

	// register index, taken from paddr[3]
	localparam logic REG_TARGET = 1'b0;
	localparam logic REG_SEARCH = 1'b1;

	// byte within a four byte table entry
	localparam logic [1:0] SEL_END_HI = 2'd0;
	localparam logic [1:0] SEL_END_LO = 2'd1;
	localparam logic [1:0] SEL_CNT_HI = 2'd2;
	localparam logic [1:0] SEL_CNT_LO = 2'd3;

	localparam logic [7:0] ONE_BYTE_MAX   = 8'd63;
	localparam logic [7:0] TWO_BYTE_MAX   = 8'd191;
	localparam logic [7:0] TWO_BYTE_TAG   = 8'd64;
	localparam logic [7:0] THREE_BYTE_TAG = 8'd192;
	localparam logic [7:0] ASCII_BASE     = 8'd65;

	localparam logic [15:0] NUM_COUNT  = 16'h0000;
	localparam logic [15:0] NUM_SEARCH = 16'hFFFF;
	localparam logic [15:0] NUM_NONE   = 16'hFFFF;
	localparam logic [15:0] POS_MAX    = 16'hFFFF;

	// first letter from the letter index, the rest from the 5-bit code fields
	function automatic logic [39:0] build_word(input logic [4:0] letter,
			input logic [19:0] code);
		logic [39:0] w;
		w[39:32] = {3'b000, letter} + ASCII_BASE;
		w[31:24] = {3'b000, code[19:15]} + ASCII_BASE;
		w[23:16] = {3'b000, code[14:10]} + ASCII_BASE;
		w[15:8]  = {3'b000, code[9:5]} + ASCII_BASE;
		w[7:0]   = {3'b000, code[4:0]} + ASCII_BASE;
		return w;
	endfunction

endpackage

>>> rtl/core/dcwl_letter_table.sv
// letter table: end offset and word count per letter, one entry per row
// assembles the four header bytes, single write port, registered read with bypass
// depends on dcwl_pkg
module dcwl_letter_table #(
	parameter int MAX_LETTERS = 32
) (
	input  logic                     clk,
	input  dcwl_pkg::table_write_t   wr,
	input  logic [IDX_W-1:0]         wr_index,
	input  logic [IDX_W-1:0]         rd_index,
	output dcwl_pkg::letter_entry_t  rd_entry,
	output dcwl_pkg::letter_entry_t  fill_entry
);

	localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;

	logic [23:0]             part_q;
	dcwl_pkg::letter_entry_t rd_q;
	dcwl_pkg::letter_entry_t table_mem_q [MAX_LETTERS];
	logic                    wr_row;

	assign fill_entry = dcwl_pkg::letter_entry_t'({part_q, wr.data});
	assign wr_row     = wr.valid && (wr.sel == dcwl_pkg::SEL_CNT_LO);
	assign rd_entry   = rd_q;

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			case (wr.sel)
				dcwl_pkg::SEL_END_HI: part_q[23:16] <= wr.data;
				dcwl_pkg::SEL_END_LO: part_q[15:8]  <= wr.data;
				dcwl_pkg::SEL_CNT_HI: part_q[7:0]   <= wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_row) begin
			table_mem_q[wr_index] <= fill_entry;
		end
	end

	// a row finished in the same cycle is forwarded to the read port
	always_ff @(posedge clk) begin
		if (wr_row && (wr_index == rd_index)) begin
			rd_q <= fill_entry;
		end else begin
			rd_q <= table_mem_q[rd_index];
		end
	end

endmodule

>>> rtl/core/delta_coded_word_list_lookup.sv
// top level of the delta coded word list lookup
// byte decoder, letter walk, result register and register port
// depends on dcwl_pkg and dcwl_letter_table
//
// The block takes a compressed five-letter dictionary one byte per cycle when
// byte_stall is low, and gives one result item on the byte marked last: a
// fetched word and its index (target_number 1 to 65534), the total word count
// (target_number 0), or the index of search_word (target_number 65535); 65535
// means not found. Header bytes fill a letter table memory (end offset and
// word count per letter); data bytes are decoded and accumulated as they
// arrive. A byte that crosses letter boundaries is held with byte_stall while
// the walk reads the next letter's entry from the table memory one entry per
// cycle, empty letters included. target_number is taken at the first byte of
// each stream; a result waiting in the output register does not hold up the
// next stream's bytes until that stream's own last byte.
module delta_coded_word_list_lookup #(
	parameter int MAX_LETTERS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  dcwl_pkg::byte_item_t   byte_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output dcwl_pkg::result_item_t result_item,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [63:0]            pwdata,
	output logic [63:0]            prdata,
	output logic                   pready
);

	localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
	localparam int CNT_W = $clog2(MAX_LETTERS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LETTERS);
	localparam logic [CNT_W:0]   MAX_NXT = (CNT_W + 1)'(MAX_LETTERS);

	typedef enum logic [3:0] {
		PH_COUNT = 4'b0001,
		PH_TABLE = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// registers
	logic [15:0]            target_q;
	logic [39:0]            search_q;
	phase_t                 phase_q;
	logic [15:0]            pos_q;
	logic [CNT_W-1:0]       total_q;
	logic [CNT_W-1:0]       li_q;
	logic [15:0]            ws_q;
	logic [19:0]            code_q;
	logic [1:0]             pend_q;
	logic [21:0]            part_q;
	logic [15:0]            ans_q;
	logic [24:0]            ans_word_q;
	logic                   settled_q;
	logic                   skip_q;
	logic [15:0]            cur_end_q;
	logic                   result_valid_q;
	dcwl_pkg::result_item_t result_item_q;

	// next state
	phase_t                 phase_d;
	logic [15:0]            pos_d;
	logic [CNT_W-1:0]       total_d;
	logic [CNT_W-1:0]       li_d;
	logic [15:0]            ws_d;
	logic [19:0]            code_d;
	logic [1:0]             pend_d;
	logic [21:0]            part_d;
	logic [15:0]            ans_d;
	logic [24:0]            ans_word_d;
	logic                   settled_d;
	logic                   skip_d;
	logic [15:0]            cur_end_d;
	dcwl_pkg::result_item_t result_d;

	logic                    cfg_wr;
	logic [7:0]              in_b;
	logic                    byte_acc;
	logic                    emit;
	logic                    need_adv;
	logic [CNT_W-1:0]        li_inc;
	logic [7:0]              search_letter;
	logic [15:0]             pos_m1;
	logic                    table_end;
	logic                    is_transition;
	dcwl_pkg::letter_entry_t rd_entry;
	dcwl_pkg::letter_entry_t fill_entry;
	dcwl_pkg::letter_entry_t ent;
	logic [CNT_W-1:0]        ent_li;
	logic [16:0]             ent_sum;
	logic                    ent_skip;
	logic [21:0]             part_ext;
	logic [19:0]             delta;
	logic                    take;
	logic [19:0]             code_new;
	logic [15:0]             ws_inc;
	logic                    match;
	logic                    hit;
	logic [CNT_W:0]          rd_nxt;
	logic [IDX_W-1:0]        rd_index;
	dcwl_pkg::table_write_t  tbl_wr;
	logic [IDX_W-1:0]        tbl_index;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			search_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				dcwl_pkg::REG_TARGET: target_q <= pwdata[15:0];
				dcwl_pkg::REG_SEARCH: search_q <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			dcwl_pkg::REG_TARGET: prdata = {48'd0, target_q};
			dcwl_pkg::REG_SEARCH: prdata = {24'd0, search_q};
			default:              prdata = '0;
		endcase
	end

	// handshake
	assign in_b     = byte_item.data_byte;
	assign need_adv = (phase_q == PH_DATA) && (li_q < total_q) && (pos_q >= cur_end_q);
	assign byte_stall = need_adv || (byte_item.last && result_valid_q && result_stall);
	assign byte_acc = byte_valid && !byte_stall;
	assign emit     = byte_acc && byte_item.last;

	assign search_letter = (ans_q == dcwl_pkg::NUM_SEARCH) ?
		(search_q[39:32] - dcwl_pkg::ASCII_BASE) : 8'hFF;

	// header table
	assign pos_m1        = pos_q - 16'd1;
	assign tbl_wr.valid  = byte_acc && (phase_q == PH_TABLE);
	assign tbl_wr.sel    = pos_m1[1:0];
	assign tbl_wr.data   = in_b;
	assign tbl_index     = pos_m1[IDX_W+1:2];
	assign table_end     = pos_q >= (16'(total_q) << 2);
	assign is_transition = tbl_wr.valid && table_end;

	// letter entry: letter 0 at the end of the header, else the next letter
	assign li_inc = li_q + CNT_W'(1);
	assign ent    = is_transition ?
		((total_q == CNT_W'(1)) ? fill_entry : rd_entry) : rd_entry;
	assign ent_li   = is_transition ? '0 : li_inc;
	assign ent_sum  = {1'b0, ws_q} + {1'b0, ent.word_count};
	assign ent_skip = (8'(ent_li) < search_letter) && (ent_sum < {1'b0, ans_q});

	// delta decode
	assign part_ext = {part_q[13:0], in_b};
	assign delta    = (pend_q == 2'd0) ? {12'd0, in_b} : part_ext[19:0];
	assign take     = byte_acc && (phase_q == PH_DATA) && !skip_q &&
		(((pend_q == 2'd0) && (in_b <= dcwl_pkg::ONE_BYTE_MAX)) || (pend_q == 2'd1));
	assign code_new = code_q + delta;
	assign ws_inc   = ws_q + 16'd1;
	assign match    = (ans_q == dcwl_pkg::NUM_SEARCH) && (8'(li_q) == search_letter) &&
		(dcwl_pkg::build_word(5'(li_q), code_new) == search_q);
	assign hit      = (ans_q != dcwl_pkg::NUM_COUNT) && (ws_inc == ans_q);

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		total_d    = total_q;
		li_d       = li_q;
		ws_d       = ws_q;
		code_d     = code_q;
		pend_d     = pend_q;
		part_d     = part_q;
		ans_d      = ans_q;
		ans_word_d = ans_word_q;
		settled_d  = settled_q;
		skip_d     = skip_q;
		cur_end_d  = cur_end_q;
		result_d   = result_item_q;

		// one letter boundary per cycle while the byte waits
		if (byte_valid && need_adv) begin
			li_d = li_inc;
			if (li_inc < total_q) begin
				code_d    = '0;
				pend_d    = '0;
				part_d    = '0;
				skip_d    = ent_skip;
				cur_end_d = ent.end_offset;
				if (ent_skip) begin
					ws_d = ent_sum[15:0];
				end
			end else begin
				phase_d = PH_DONE;
			end
		end

		if (byte_acc) begin
			case (phase_q)
				PH_COUNT: begin
					ans_d   = target_q;
					total_d = (in_b > 8'(MAX_LETTERS)) ? MAX_CNT : CNT_W'(in_b);
					phase_d = (in_b == 8'd0) ? PH_DONE : PH_TABLE;
				end
				PH_TABLE: begin
					if (table_end) begin
						li_d      = '0;
						code_d    = '0;
						pend_d    = '0;
						part_d    = '0;
						skip_d    = ent_skip;
						cur_end_d = ent.end_offset;
						phase_d   = PH_DATA;
						if (ent_skip) begin
							ws_d = ent_sum[15:0];
						end
					end
				end
				PH_DATA: begin
					if (!skip_q) begin
						if (pend_q == 2'd0) begin
							if (in_b > dcwl_pkg::TWO_BYTE_MAX) begin
								part_d = {14'd0, in_b - dcwl_pkg::THREE_BYTE_TAG};
								pend_d = 2'd2;
							end else if (in_b > dcwl_pkg::ONE_BYTE_MAX) begin
								part_d = {14'd0, in_b - dcwl_pkg::TWO_BYTE_TAG};
								pend_d = 2'd1;
							end
						end else begin
							part_d = part_ext;
							pend_d = pend_q - 2'd1;
						end
						if (take) begin
							code_d = code_new;
							ws_d   = ws_inc;
							if (match) begin
								ans_d   = ws_inc;
								phase_d = PH_DONE;
							end else if (hit) begin
								ans_word_d = {5'(li_q), code_new};
								settled_d  = 1'b1;
								phase_d    = PH_DONE;
							end
						end
					end
				end
				default: ;
			endcase
			if (pos_q != dcwl_pkg::POS_MAX) begin
				pos_d = pos_q + 16'd1;
			end
		end

		if (emit) begin
			if (ans_d == dcwl_pkg::NUM_COUNT) begin
				result_d.result_number = ws_d;
			end else if (ws_d != ans_d) begin
				result_d.result_number = dcwl_pkg::NUM_NONE;
			end else begin
				result_d.result_number = ans_d;
			end
			result_d.word_written = settled_d;
			result_d.out_word     = settled_d ?
				dcwl_pkg::build_word(ans_word_d[24:20], ans_word_d[19:0]) : search_q;
			// stream over: back to the start of a new dictionary
			phase_d    = PH_COUNT;
			pos_d      = '0;
			total_d    = '0;
			li_d       = '0;
			ws_d       = '0;
			code_d     = '0;
			pend_d     = '0;
			part_d     = '0;
			ans_d      = '0;
			ans_word_d = '0;
			settled_d  = 1'b0;
			skip_d     = 1'b0;
		end
	end

	// table read address follows the letter after the current one
	assign rd_nxt   = {1'b0, li_d} + (CNT_W + 1)'(1);
	assign rd_index = ((phase_d == PH_DATA) && (rd_nxt < MAX_NXT)) ? rd_nxt[IDX_W-1:0] : '0;

	dcwl_letter_table #(
		.MAX_LETTERS(MAX_LETTERS)
	) u_table (
		.clk       (clk),
		.wr        (tbl_wr),
		.wr_index  (tbl_index),
		.rd_index  (rd_index),
		.rd_entry  (rd_entry),
		.fill_entry(fill_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			pos_q      <= '0;
			total_q    <= '0;
			li_q       <= '0;
			ws_q       <= '0;
			code_q     <= '0;
			pend_q     <= '0;
			part_q     <= '0;
			ans_q      <= '0;
			ans_word_q <= '0;
			settled_q  <= 1'b0;
			skip_q     <= 1'b0;
			cur_end_q  <= '0;
		end else begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			total_q    <= total_d;
			li_q       <= li_d;
			ws_q       <= ws_d;
			code_q     <= code_d;
			pend_q     <= pend_d;
			part_q     <= part_d;
			ans_q      <= ans_d;
			ans_word_q <= ans_word_d;
			settled_q  <= settled_d;
			skip_q     <= skip_d;
			cur_end_q  <= cur_end_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_item_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_item_q;

`ifndef SYNTHESIS
	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (li_q < total_q))
		else $error("letter index past letter total in data phase");

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("delta byte count out of range");

	a_walk_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && need_adv) |=> $stable(pos_q))
		else $error("byte position moved during letter walk");

	a_emit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (result_valid && (phase_q == PH_COUNT) && (pos_q == 16'd0)))
		else $error("last item did not give a result and restart");

	a_settled_done: assert property (@(posedge clk) disable iff (!arst_n)
		settled_q |-> (phase_q == PH_DONE))
		else $error("answer settled outside done phase");
`endif

endmodule

>>> test/tb_delta_coded_word_list_lookup.sv
// testbench for delta_coded_word_list_lookup: feeds compressed dictionary streams
// and checks every result item against a cycle-free predictor kept in this file or a written want
// depends on dcwl_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;
	import dcwl_pkg::*;

	localparam int LETTER_SLOTS  = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PRESS_FIRST   = 10;

	typedef enum logic [1:0] {STAGE_COUNT, STAGE_TABLE, STAGE_DATA, STAGE_DONE} stage_t;

	typedef struct packed {
		logic         load;
		logic [15:0]  tgt;
		logic [39:0]  sw;
		byte_item_t   item;
		logic         typed;
		result_item_t want;
	} plan_row_t;

	logic         clk;
	logic         arst_n;
	logic         byte_valid;
	logic         byte_stall;
	byte_item_t   byte_item;
	logic         result_valid;
	logic         result_stall;
	result_item_t result_item;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;

	// register copies as the block should hold them
	logic [15:0] cfg_target;
	logic [39:0] cfg_search;

	// dictionary walk state
	stage_t      stage;
	logic [15:0] dict_pos;
	logic [15:0] end_tab [LETTER_SLOTS];
	logic [15:0] cnt_tab [LETTER_SLOTS];
	logic [5:0]  n_letters;
	logic [5:0]  cur_letter;
	logic [15:0] word_tally;
	logic [19:0] code_acc;
	logic [1:0]  pend;
	logic [21:0] part;
	logic [15:0] goal;
	logic [24:0] got_word;
	logic        got;
	logic        skipping;

	result_item_t awaited[$];
	int           mismatches = 0;
	logic         calm = 1'b0;
	logic         hold_off_req = 1'b0;

	delta_coded_word_list_lookup i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] due);
		$display("mismatch %s: got %h, want %h at %0t", what, seen, due, $realtime);
		mismatches++;
	endtask

	function automatic logic [39:0] spell(input logic [4:0] letter, input logic [19:0] code);
		logic [39:0] w;
		w[39:32] = {3'b000, letter} + 8'd65;
		for (int j = 0; j < 4; j++)
			w[31 - 8 * j -: 8] = {3'b000, code[19 - 5 * j -: 5]} + 8'd65;
		return w;
	endfunction

	// letter index being searched, or one that is never reached
	function automatic logic [7:0] probe_letter();
		if (goal != NUM_SEARCH)
			return 8'hFF;
		return cfg_search[39:32] - 8'd65;
	endfunction

	function automatic void clear_stream();
		stage      = STAGE_COUNT;
		dict_pos   = '0;
		n_letters  = '0;
		cur_letter = '0;
		word_tally = '0;
		code_acc   = '0;
		pend       = '0;
		part       = '0;
		goal       = '0;
		got_word   = '0;
		got        = 1'b0;
		skipping   = 1'b0;
		for (int i = 0; i < LETTER_SLOTS; i++) begin
			end_tab[i] = '0;
			cnt_tab[i] = '0;
		end
	endfunction

	// letters below the searched one are skipped whole while their count stays short
	function automatic void open_letter();
		code_acc = '0;
		pend     = '0;
		part     = '0;
		skipping = 1'b0;
		if (cur_letter < 6'd32 && {2'b00, cur_letter} < probe_letter()) begin
			if ({1'b0, word_tally} + {1'b0, cnt_tab[cur_letter[4:0]]} < {1'b0, goal}) begin
				word_tally = word_tally + cnt_tab[cur_letter[4:0]];
				skipping   = 1'b1;
			end
		end
	endfunction

	function automatic void take_delta(input logic [21:0] delta);
		code_acc   = code_acc + delta[19:0];
		word_tally = word_tally + 16'd1;
		if (goal == NUM_SEARCH && {2'b00, cur_letter} == probe_letter() &&
				spell(cur_letter[4:0], code_acc) == cfg_search) begin
			goal  = word_tally;
			stage = STAGE_DONE;
			return;
		end
		if (goal != NUM_COUNT && word_tally == goal) begin
			got_word = {cur_letter[4:0], code_acc};
			got      = 1'b1;
			stage    = STAGE_DONE;
		end
	endfunction

	task automatic decode_dictionary_byte(input byte_item_t it, output logic has,
			output result_item_t res);
		logic [7:0]  b;
		logic [15:0] p;
		logic [15:0] slot;
		b    = it.data_byte;
		p    = dict_pos;
		has  = 1'b0;
		res  = '0;
		slot = p - 16'd1;
		case (stage)
			STAGE_COUNT: begin
				goal      = cfg_target;
				n_letters = (b > 8'd32) ? 6'd32 : b[5:0];
				stage     = (n_letters == 6'd0) ? STAGE_DONE : STAGE_TABLE;
			end
			STAGE_TABLE: begin
				if (slot[15:2] < 14'd32) begin
					case (slot[1:0])
						SEL_END_HI: end_tab[slot[6:2]][15:8] = b;
						SEL_END_LO: end_tab[slot[6:2]][7:0]  = b;
						SEL_CNT_HI: cnt_tab[slot[6:2]][15:8] = b;
						default:    cnt_tab[slot[6:2]][7:0]  = b;
					endcase
				end
				if (p >= {8'd0, n_letters, 2'b00}) begin
					cur_letter = '0;
					open_letter();
					stage = STAGE_DATA;
				end
			end
			STAGE_DATA: begin
				// a byte may cross several letter ends, empty letters included
				while (cur_letter < n_letters && p >= end_tab[cur_letter[4:0]]) begin
					cur_letter = cur_letter + 6'd1;
					if (cur_letter < n_letters)
						open_letter();
				end
				if (cur_letter >= n_letters) begin
					stage = STAGE_DONE;
				end else if (!skipping) begin
					if (pend == 2'd0) begin
						if (b > TWO_BYTE_MAX) begin
							part = {14'd0, b - THREE_BYTE_TAG};
							pend = 2'd2;
						end else if (b > ONE_BYTE_MAX) begin
							part = {14'd0, b - TWO_BYTE_TAG};
							pend = 2'd1;
						end else begin
							take_delta({14'd0, b});
						end
					end else begin
						part = {part[13:0], b};
						pend = pend - 2'd1;
						if (pend == 2'd0)
							take_delta(part);
					end
				end
			end
			default: ;
		endcase
		if (dict_pos != POS_MAX)
			dict_pos = dict_pos + 16'd1;
		if (it.last) begin
			if (goal == NUM_COUNT)
				res.result_number = word_tally;
			else if (word_tally != goal)
				res.result_number = NUM_NONE;
			else
				res.result_number = goal;
			res.word_written = got;
			res.out_word     = got ? spell(got_word[24:20], got_word[19:0]) : cfg_search;
			has = 1'b1;
			clear_stream();
		end
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// registers change only with the block drained and quiet
	task automatic settle_regs(input logic [15:0] tgt, input logic [39:0] sw);
		byte_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_TARGET, {48'd0, tgt});
		write_reg(REG_SEARCH, {24'd0, sw});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_target = tgt;
		cfg_search = sw;
	endtask

	task automatic offer_byte(input byte_item_t it, input logic typed, input result_item_t want);
		logic         has;
		result_item_t guess;
		if (!calm && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		decode_dictionary_byte(it, has, guess);
		if (has)
			awaited.push_back(typed ? want : guess);
	endtask

	function automatic plan_row_t data_row(input logic [7:0] b, input logic last);
		plan_row_t r;
		r = '0;
		r.item.data_byte = b;
		r.item.last      = last;
		return r;
	endfunction

	function automatic plan_row_t full_row(input logic load, input logic [15:0] tgt,
			input logic [39:0] sw, input logic [7:0] b, input logic last, input logic typed,
			input logic [15:0] num, input logic ww, input logic [39:0] word);
		plan_row_t r;
		r = data_row(b, last);
		r.load  = load;
		r.tgt   = tgt;
		r.sw    = sw;
		r.typed = typed;
		r.want.result_number = num;
		r.want.word_written  = ww;
		r.want.out_word      = word;
		return r;
	endfunction

	initial begin : result_side
		result_item_t want;
		int           stall_left;
		int           hold_left;
		stall_left   = 0;
		hold_left    = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (awaited.size() == 0) begin
					flag_mismatch("unexpected result", 64'(result_item), '0);
				end else begin
					want = awaited.pop_front();
					if (result_item.result_number !== want.result_number)
						flag_mismatch("result_number", 64'(result_item.result_number),
							64'(want.result_number));
					if (result_item.word_written !== want.word_written)
						flag_mismatch("word_written", 64'(result_item.word_written),
							64'(want.word_written));
					if (result_item.out_word !== want.out_word)
						flag_mismatch("out_word", 64'(result_item.out_word), 64'(want.out_word));
				end
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (hold_off_req) begin
				// long hold-off so that the block backs up onto its input
				hold_off_req = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left   = $urandom_range(1, 8) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		plan_row_t   plan[$];
		logic [7:0]  bytes_q[$];
		logic [7:0]  body[$];
		logic [39:0] lexicon[$];
		logic [15:0] ends [LETTER_SLOTS];
		logic [15:0] counts [LETTER_SLOTS];
		logic [31:0] dv;
		logic [31:0] cb;
		logic [31:0] span;
		logic [63:0] r64;
		logic [19:0] code;
		logic [15:0] tgt;
		logic [39:0] sw;
		logic [7:0]  junk;
		byte_item_t  it;
		int          nl, n_words, enc, k, cut, variant, mode, pick, word_total;
		int          random_sent, s, guard;

		byte_valid = 1'b0;
		byte_item  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		arst_n     = 1'b0;
		cfg_target = '0;
		cfg_search = '0;
		clear_stream();
		random_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty dictionary right after reset: count mode with nothing counted
		plan.push_back(full_row(0, 16'h0000, 40'h0, 8'h00, 1, 1, 16'h0000, 0, 40'h0));
		// one letter, one- and two-byte deltas, a three-byte delta cut by last
		plan.push_back(data_row(8'h01, 0));
		plan.push_back(data_row(8'h00, 0));
		plan.push_back(data_row(8'h09, 0));
		plan.push_back(data_row(8'h00, 0));
		plan.push_back(data_row(8'h02, 0));
		plan.push_back(data_row(8'h05, 0));
		plan.push_back(data_row(8'h40, 0));
		plan.push_back(data_row(8'h01, 0));
		plan.push_back(data_row(8'hC0, 1));
		// search for the first word of the same letter
		plan.push_back(full_row(1, NUM_SEARCH, 40'h4141414146, 8'h01, 0, 0, '0, 0, '0));
		plan.push_back(data_row(8'h00, 0));
		plan.push_back(data_row(8'h08, 0));
		plan.push_back(data_row(8'h00, 0));
		plan.push_back(data_row(8'h02, 0));
		plan.push_back(data_row(8'h05, 0));
		plan.push_back(data_row(8'h40, 0));
		plan.push_back(data_row(8'h01, 1));
		// letter count above the limit, stream ends on the count byte: out of range
		plan.push_back(full_row(1, 16'hFFFE, 40'hFFFFFFFFFF, 8'hFF, 1, 1, NUM_NONE, 0,
			40'hFFFFFFFFFF));
		// fetch of word one with the largest one-byte delta
		plan.push_back(full_row(1, 16'h0001, 40'h0, 8'h01, 0, 0, '0, 0, '0));
		plan.push_back(data_row(8'h00, 0));
		plan.push_back(data_row(8'h06, 0));
		plan.push_back(data_row(8'h00, 0));
		plan.push_back(data_row(8'h01, 0));
		plan.push_back(data_row(8'h3F, 1));

		foreach (plan[j]) begin
			if (plan[j].load)
				settle_regs(plan[j].tgt, plan[j].sw);
			offer_byte(plan[j].item, plan[j].typed, plan[j].want);
		end

		for (s = 0; !(random_sent >= 450 && s >= 40); s++) begin
			if (random_sent >= 350 && s >= 32)
				calm = 1'b1;

			// well-formed dictionary with random letters, words and delta sizes
			bytes_q.delete();
			body.delete();
			lexicon.delete();
			word_total = 0;
			case ($urandom_range(0, 19))
				0:       cb = 32;
				1:       cb = $urandom_range(33, 255);
				2, 3:    cb = $urandom_range(4, 8);
				default: cb = $urandom_range(1, 3);
			endcase
			nl = (cb > 32) ? 32 : cb;
			for (int li = 0; li < nl; li++) begin
				n_words = (nl > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
				code = '0;
				for (int w = 0; w < n_words; w++) begin
					enc = $urandom_range(0, 2);
					if (enc == 0) begin
						dv = $urandom_range(0, 63);
						body.push_back(dv[7:0]);
					end else if (enc == 1) begin
						dv = $urandom_range(0, 32767);
						body.push_back({1'b0, dv[14:8]} + TWO_BYTE_TAG);
						body.push_back(dv[7:0]);
					end else begin
						dv = $urandom_range(0, 32'h3FFFFF);
						body.push_back({2'b00, dv[21:16]} + THREE_BYTE_TAG);
						body.push_back(dv[15:8]);
						body.push_back(dv[7:0]);
					end
					code = code + dv[19:0];
					lexicon.push_back(spell(li[4:0], code));
				end
				span = 1 + 4 * nl + body.size();
				ends[li]   = span[15:0];
				counts[li] = n_words[15:0];
				word_total += n_words;
			end
			// now and then a table entry that disagrees with the data
			if ($urandom_range(0, 7) == 0) begin
				k = $urandom_range(0, nl - 1);
				if ($urandom_range(0, 1) == 1) begin
					dv = $urandom_range(0, 7);
					counts[k] = dv[15:0];
				end else begin
					dv = $urandom_range(0, ends[k] + 3);
					ends[k] = dv[15:0];
				end
			end
			bytes_q.push_back(cb[7:0]);
			for (int li = 0; li < nl; li++) begin
				bytes_q.push_back(ends[li][15:8]);
				bytes_q.push_back(ends[li][7:0]);
				bytes_q.push_back(counts[li][15:8]);
				bytes_q.push_back(counts[li][7:0]);
			end
			foreach (body[j])
				bytes_q.push_back(body[j]);

			// broken streams: early last, trailing bytes, plain noise
			variant = $urandom_range(0, 19);
			if (variant < 2) begin
				cut = $urandom_range(1, bytes_q.size());
				while (bytes_q.size() > cut)
					junk = bytes_q.pop_back();
			end else if (variant < 4) begin
				repeat ($urandom_range(1, 4)) begin
					dv = $urandom;
					bytes_q.push_back(dv[7:0]);
				end
			end else if (variant < 6) begin
				bytes_q.delete();
				repeat ($urandom_range(1, 8)) begin
					dv = $urandom;
					bytes_q.push_back(dv[7:0]);
				end
			end

			tgt  = cfg_target;
			sw   = cfg_search;
			mode = $urandom_range(0, 19);
			r64  = {$urandom, $urandom};
			if (mode < 6) begin
				tgt = NUM_COUNT;
			end else if (mode < 13) begin
				if ($urandom_range(0, 7) == 0)
					dv = ($urandom_range(0, 1) == 1) ? 32'hFFFE : $urandom_range(1, 16'hFFFE);
				else
					dv = $urandom_range(1, word_total + 2);
				tgt = dv[15:0];
			end else begin
				tgt  = NUM_SEARCH;
				pick = $urandom_range(0, 19);
				if (lexicon.size() != 0 && pick < 14)
					sw = lexicon[$urandom_range(0, lexicon.size() - 1)];
				else if (lexicon.size() != 0 && pick < 17)
					sw = lexicon[$urandom_range(0, lexicon.size() - 1)] ^
						(40'd1 << $urandom_range(0, 4));
				else
					sw = r64[39:0];
			end
			if (mode < 13 && $urandom_range(0, 3) == 0)
				sw = r64[39:0];

			if (s == PRESS_FIRST)
				hold_off_req = 1'b1;
			// no register writes while the hold-off lets the block fill up
			if (s < PRESS_FIRST || s >= PRESS_FIRST + 4) begin
				if (tgt != cfg_target || sw != cfg_search || $urandom_range(0, 3) == 0)
					settle_regs(tgt, sw);
			end

			foreach (bytes_q[j]) begin
				it.data_byte = bytes_q[j];
				it.last      = (j == bytes_q.size() - 1);
				offer_byte(it, 1'b0, '0);
				random_sent++;
			end
		end

		byte_valid <= 1'b0;
		guard = 0;
		while (awaited.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES + 10) @(posedge clk);
		if (awaited.size() != 0)
			flag_mismatch("results never arrived", 64'(awaited.size()), '0);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
